@@ hdl/calt_pkg.sv @@
package calt_pkg;

    localparam int TABLE_DEPTH_DEF  = 32;
    localparam int ACCESS_SLOTS_DEF = 4;
    localparam int TYPE_ID_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 8;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_APPLY,
        S_COMMIT,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] type_id_0;
        logic [15:0] type_id_1;
        logic [15:0] type_id_2;
        logic [15:0] type_id_3;
        logic [3:0]  write_mask;
        logic [3:0]  slot_valid_mask;
    } in_t;

    typedef struct packed {
        logic        granted;
        status_t     status;
        logic [5:0]  free_entries;
    } out_t;

endpackage

@@ hdl/calt_ram.sv @@
module calt_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/component_access_lock_table.sv @@
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data  (in_t)
// out     | output    | out_valid / out_ready | out_data (out_t)
//
// A transaction runs these steps from one accept to the next: the accepting cycle, a sweep
// of the entry RAM through its single read port, a conflict check, an apply step that goes
// slot by slot, a write back that goes slot by slot, and the response. A conflict skips
// apply and write back; a failing slot ends the apply step early and skips write back.
// Reset clears all valid bits; the entry RAM needs no clearing pass.
// A finished result waits in the output register; the next transaction may
// start meanwhile, and only the response step waits on out_ready.
module component_access_lock_table
    import calt_pkg::*;
    #(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int ACCESS_SLOTS = ACCESS_SLOTS_DEF,
    parameter int TYPE_ID_BITS = TYPE_ID_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
    )
    (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
    );

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = (ACCESS_SLOTS > 1) ? $clog2(ACCESS_SLOTS) : 1;
    localparam int NW = $clog2(ACCESS_SLOTS + 1);
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = TYPE_ID_BITS;
    localparam int CB = COUNT_BITS;
    localparam int RW = TW + CB;
    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    fsm_t               state_reg, state_next;
    in_t                in_reg, in_next;
    out_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [FW-1:0]      free_cnt_reg, free_cnt_next;
    logic [IW:0]        issue_reg, issue_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IW-1:0]      scan_d_reg, scan_d_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [NW-1:0]      free_n_reg, free_n_next;
    logic [NW-1:0]      alloc_n_reg, alloc_n_next;
    logic [NW-1:0]      freed_n_reg, freed_n_next;
    logic [IW-1:0]      free_list_reg [ACCESS_SLOTS];
    logic [IW-1:0]      free_list_next [ACCESS_SLOTS];
    logic               present_reg [ACCESS_SLOTS];
    logic               present_next [ACCESS_SLOTS];
    logic [IW-1:0]      idx_reg [ACCESS_SLOTS];
    logic [IW-1:0]      idx_next [ACCESS_SLOTS];
    logic [CB-1:0]      readers_reg [ACCESS_SLOTS];
    logic [CB-1:0]      readers_next [ACCESS_SLOTS];

    logic [TW-1:0]      key [ACCESS_SLOTS];
    logic [15:0]        raw_type [4];
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;

    assign raw_type[0] = in_reg.type_id_0;
    assign raw_type[1] = in_reg.type_id_1;
    assign raw_type[2] = in_reg.type_id_2;
    assign raw_type[3] = in_reg.type_id_3;

    always_comb
    begin
        for (int k = 0; k < ACCESS_SLOTS; k++)
        begin
            key[k] = TW'(raw_type[k]);
        end
    end

    calt_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_entry_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            free_cnt_reg  <= FW'(TABLE_DEPTH);
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            free_cnt_reg  <= free_cnt_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        out_reg     <= out_next;
        status_reg  <= status_next;
        issue_reg   <= issue_next;
        scan_d_reg  <= scan_d_next;
        slot_reg    <= slot_next;
        free_n_reg  <= free_n_next;
        alloc_n_reg <= alloc_n_next;
        freed_n_reg <= freed_n_next;
        free_list_reg <= free_list_next;
        present_reg <= present_next;
        idx_reg     <= idx_next;
        readers_reg <= readers_next;
    end

    always_comb
    begin
        logic [SW-1:0] s;
        logic          used;
        logic          rd;
        logic          hit;

        state_next     = state_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        valid_next     = valid_reg;
        free_cnt_next  = free_cnt_reg;
        issue_next     = issue_reg;
        rd_vld_next    = rd_vld_reg;
        scan_d_next    = scan_d_reg;
        slot_next      = slot_reg;
        free_n_next    = free_n_reg;
        alloc_n_next   = alloc_n_reg;
        freed_n_next   = freed_n_reg;
        free_list_next = free_list_reg;
        present_next   = present_reg;
        idx_next       = idx_reg;
        readers_next   = readers_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = issue_reg[IW-1:0];
        s              = slot_reg;
        used           = in_reg.slot_valid_mask[s];
        rd             = ~in_reg.write_mask[s];
        hit            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next      = in_data;
                    state_next   = S_SCAN;
                    issue_next   = '0;
                    rd_vld_next  = 1'b0;
                    free_n_next  = '0;
                    alloc_n_next = '0;
                    freed_n_next = '0;
                    status_next  = ST_OK;
                    for (int k = 0; k < ACCESS_SLOTS; k++)
                    begin
                        present_next[k] = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue_reg != (IW+1)'(TABLE_DEPTH))
                begin
                    issue_next  = issue_reg + 1'b1;
                    rd_vld_next = 1'b1;
                    scan_d_next = issue_reg[IW-1:0];
                end
                else
                begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg)
                    begin
                        state_next = S_CHECK;
                    end
                end
                if (rd_vld_reg)
                begin
                    if (valid_reg[scan_d_reg])
                    begin
                        for (int k = 0; k < ACCESS_SLOTS; k++)
                        begin
                            if (in_reg.slot_valid_mask[k] && ram_rdata[RW-1:CB] == key[k])
                            begin
                                present_next[k] = 1'b1;
                                idx_next[k]     = scan_d_reg;
                                readers_next[k] = ram_rdata[CB-1:0];
                            end
                        end
                    end
                    else if (free_n_reg < NW'(ACCESS_SLOTS))
                    begin
                        free_list_next[free_n_reg[SW-1:0]] = scan_d_reg;
                        free_n_next = free_n_reg + 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if (in_reg.operation == OP_ACQUIRE)
                begin
                    for (int k = 0; k < ACCESS_SLOTS; k++)
                    begin
                        if (in_reg.slot_valid_mask[k] && present_reg[k]
                            && (in_reg.write_mask[k] || readers_reg[k] == '0))
                        begin
                            hit = 1'b1;
                        end
                    end
                end
                slot_next = '0;
                if (hit)
                begin
                    status_next = ST_CONFLICT;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (used)
                begin
                    if (in_reg.operation == OP_ACQUIRE)
                    begin
                        if (!present_reg[s])
                        begin
                            if (alloc_n_reg == free_n_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                alloc_n_next = alloc_n_reg + 1'b1;
                                for (int k = 0; k < ACCESS_SLOTS; k++)
                                begin
                                    if (in_reg.slot_valid_mask[k] && key[k] == key[s])
                                    begin
                                        present_next[k] = 1'b1;
                                        idx_next[k]     = free_list_reg[alloc_n_reg[SW-1:0]];
                                        readers_next[k] = CB'(rd);
                                    end
                                end
                            end
                        end
                        else if (rd && readers_reg[s] == COUNT_MAX)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            for (int k = 0; k < ACCESS_SLOTS; k++)
                            begin
                                if (in_reg.slot_valid_mask[k] && key[k] == key[s])
                                begin
                                    readers_next[k] = readers_reg[s] + CB'(rd);
                                end
                            end
                        end
                    end
                    else if (!present_reg[s])
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else
                    begin
                        if (readers_reg[s] <= CB'(1))
                        begin
                            freed_n_next = freed_n_reg + 1'b1;
                        end
                        for (int k = 0; k < ACCESS_SLOTS; k++)
                        begin
                            if (in_reg.slot_valid_mask[k] && key[k] == key[s])
                            begin
                                if (readers_reg[s] <= CB'(1))
                                begin
                                    present_next[k] = 1'b0;
                                end
                                else
                                begin
                                    readers_next[k] = readers_reg[s] - 1'b1;
                                end
                            end
                        end
                    end
                end
                if (status_next != ST_OK)
                begin
                    state_next = S_RESP;
                end
                else if (s == SW'(ACCESS_SLOTS - 1))
                begin
                    slot_next  = '0;
                    state_next = S_COMMIT;
                end
                else
                begin
                    slot_next = s + 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (used)
                begin
                    if (present_reg[s])
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = idx_reg[s];
                        ram_wdata   = {key[s], readers_reg[s]};
                        valid_next[idx_reg[s]] = 1'b1;
                    end
                    else
                    begin
                        valid_next[idx_reg[s]] = 1'b0;
                    end
                end
                if (s == SW'(ACCESS_SLOTS - 1))
                begin
                    free_cnt_next = free_cnt_reg + FW'(freed_n_reg) - FW'(alloc_n_reg);
                    state_next    = S_RESP;
                end
                else
                begin
                    slot_next = s + 1'b1;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.granted      = (status_reg == ST_OK);
                    out_next.status       = status_reg;
                    out_next.free_entries = 6'(free_cnt_reg);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_free_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= FW'(TABLE_DEPTH))
        else $error("free count above table depth");

    a_free_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(~valid_reg) == 32'(free_cnt_reg))
        else $error("free count disagrees with valid bits");

    a_write_only_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_COMMIT && status_reg == ST_OK)
        else $error("entry RAM written outside commit");

    a_granted_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.granted == (out_reg.status == ST_OK))
        else $error("granted disagrees with status");

endmodule

@@ verif/component_access_lock_table_tb.sv @@
module component_access_lock_table_tb;
    import calt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int SLOTS       = ACCESS_SLOTS_DEF;
    localparam int COUNT_TOP   = (1 << COUNT_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int CALM_TAIL   = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // shadow of the lock table
    bit          lock_used [DEPTH];
    logic [15:0] lock_type [DEPTH];
    int          lock_cnt  [DEPTH];

    in_t  pending_q[$];
    bit   pause_q[$];
    out_t grant_q[$];
    in_t  issued_q[$];

    int errors = 0;
    int cycles = 0;
    int in_hold = 0;
    int out_hold = 0;
    bit calm = 1'b0;

    component_access_lock_table uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] slot_type(in_t d, int s);
        case (s)
            0: return d.type_id_0;
            1: return d.type_id_1;
            2: return d.type_id_2;
            default: return d.type_id_3;
        endcase
    endfunction

    function automatic int lookup(bit u[DEPTH], logic [15:0] t[DEPTH], logic [15:0] key);
        for (int i = 0; i < DEPTH; i++)
            if (u[i] && t[i] == key)
                return i;
        return -1;
    endfunction

    // applies one transaction to the shadow table, returns the expected response
    function automatic out_t lock_update(in_t d);
        bit          wu [DEPTH];
        logic [15:0] wt [DEPTH];
        int          wc [DEPTH];
        status_t     st;
        int          e, f, rd, nfree;
        out_t        r;
        st = ST_OK;
        wu = lock_used;
        wt = lock_type;
        wc = lock_cnt;
        if (d.operation == OP_ACQUIRE) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (d.slot_valid_mask[s] && st == ST_OK) begin
                    e = lookup(lock_used, lock_type, slot_type(d, s));
                    if (e >= 0 && (d.write_mask[s] || lock_cnt[e] == 0))
                        st = ST_CONFLICT;
                end
            end
            for (int s = 0; s < SLOTS; s++) begin
                if (d.slot_valid_mask[s] && st == ST_OK) begin
                    rd = d.write_mask[s] ? 0 : 1;
                    e = lookup(wu, wt, slot_type(d, s));
                    if (e < 0) begin
                        f = 0;
                        while (f < DEPTH && wu[f])
                            f++;
                        if (f >= DEPTH)
                            st = ST_FULL;
                        else begin
                            wu[f] = 1'b1;
                            wt[f] = slot_type(d, s);
                            wc[f] = rd;
                        end
                    end else if (wc[e] + rd > COUNT_TOP)
                        st = ST_FULL;
                    else
                        wc[e] += rd;
                end
            end
        end else begin
            for (int s = 0; s < SLOTS; s++) begin
                if (d.slot_valid_mask[s] && st == ST_OK) begin
                    e = lookup(wu, wt, slot_type(d, s));
                    if (e < 0)
                        st = ST_UNKNOWN;
                    else if (wc[e] <= 1)
                        wu[e] = 1'b0;
                    else
                        wc[e] -= 1;
                end
            end
        end
        if (st == ST_OK) begin
            lock_used = wu;
            lock_type = wt;
            lock_cnt = wc;
        end
        nfree = 0;
        for (int i = 0; i < DEPTH; i++)
            if (!lock_used[i])
                nfree++;
        r.granted = (st == ST_OK);
        r.status = st;
        r.free_entries = nfree[5:0];
        return r;
    endfunction

    task automatic add_job(logic op, logic [15:0] t0, logic [15:0] t1, logic [15:0] t2,
                           logic [15:0] t3, logic [3:0] wm, logic [3:0] vm, bit pause);
        in_t d;
        d.operation = op;
        d.type_id_0 = t0;
        d.type_id_1 = t1;
        d.type_id_2 = t2;
        d.type_id_3 = t3;
        d.write_mask = wm;
        d.slot_valid_mask = vm;
        pending_q.push_back(d);
        pause_q.push_back(pause);
        if (op == OP_ACQUIRE && vm != 4'h0)
            issued_q.push_back(d);
    endtask

    function automatic logic [15:0] pick_type();
        if ($urandom_range(0, 15) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 39));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            if (in_valid && in_ready)
                grant_q.push_back(lock_update(in_data));
            if (!in_valid || in_ready) begin
                if (in_hold > 0) begin
                    in_hold--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() == 0 ||
                             (pause_q[0] && (grant_q.size() > 0 || in_valid))) begin
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    in_hold = $urandom_range(1, 9) - 1;
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data <= pending_q.pop_front();
                    void'(pause_q.pop_front());
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        out_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout at %0t", $realtime);
                $display("status: fail");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (grant_q.size() == 0) begin
                    $display("%0t unexpected transaction: actual %0d/%0d/%0d", $realtime,
                             out_data.granted, out_data.status, out_data.free_entries);
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    if (want.granted !== out_data.granted) begin
                        $display("%0t granted: expected %0d actual %0d", $realtime,
                                 want.granted, out_data.granted);
                        errors++;
                    end
                    if (want.status !== out_data.status) begin
                        $display("%0t status: expected %0d actual %0d", $realtime,
                                 want.status, out_data.status);
                        errors++;
                    end
                    if (want.free_entries !== out_data.free_entries) begin
                        $display("%0t free_entries: expected %0d actual %0d", $realtime,
                                 want.free_entries, out_data.free_entries);
                        errors++;
                    end
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_hold = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        calm <= (pending_q.size() < CALM_TAIL);

    initial begin
        int   idx;
        in_t  d;
        logic [15:0] t;
        for (int i = 0; i < DEPTH; i++) begin
            lock_used[i] = 1'b0;
            lock_type[i] = '0;
            lock_cnt[i] = 0;
        end

        // directed
        add_job(OP_ACQUIRE, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0, 4'h0, 0);      // empty job
        add_job(OP_RELEASE, 16'h1234, 16'h0, 16'h0, 16'h0, 4'h0, 4'h1, 0);   // unknown
        add_job(OP_ACQUIRE, 16'h0000, 16'hFFFF, 16'h0, 16'h0, 4'h3, 4'h3, 0);
        add_job(OP_ACQUIRE, 16'hFFFF, 16'h0, 16'h0, 16'h0, 4'h0, 4'h1, 0);   // read vs writer
        add_job(OP_ACQUIRE, 16'h0005, 16'h0005, 16'h0006, 16'h0006, 4'h4, 4'hF, 0);
        add_job(OP_ACQUIRE, 16'h0005, 16'h0, 16'h0, 16'h0, 4'h0, 4'h1, 0);   // reader shares
        add_job(OP_ACQUIRE, 16'h0005, 16'h0, 16'h0, 16'h0, 4'h1, 4'h1, 0);   // write vs reader
        add_job(OP_RELEASE, 16'h0005, 16'h0005, 16'h0005, 16'h0006, 4'h0, 4'hF, 0);
        add_job(OP_RELEASE, 16'h0006, 16'h0, 16'h0, 16'h0, 4'h0, 4'h1, 0);
        add_job(OP_RELEASE, 16'h0000, 16'hFFFF, 16'h7, 16'h0, 4'hF, 4'h7, 0);
        add_job(OP_RELEASE, 16'h0000, 16'hFFFF, 16'h0, 16'h0, 4'hF, 4'h3, 0);
        // fill the table, then one more type
        for (int j = 0; j < 8; j++)
            add_job(OP_ACQUIRE, 16'(100 + 4 * j), 16'(101 + 4 * j), 16'(102 + 4 * j),
                    16'(103 + 4 * j), 4'hF, 4'hF, 0);
        add_job(OP_ACQUIRE, 16'hAAAA, 16'h0, 16'h0, 16'h0, 4'h0, 4'h1, 0);
        add_job(OP_ACQUIRE, 16'd100, 16'hAAAA, 16'h0, 16'h0, 4'h0, 4'h3, 1);

        for (int i = 0; i < 1850; i++) begin
            if (i == 600) begin
                // saturate one reader count, then drain it
                for (int j = 0; j < 70; j++)
                    add_job(OP_ACQUIRE, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h5A5A,
                            4'h0, 4'hF, 0);
                for (int j = 0; j < 70; j++)
                    add_job(OP_RELEASE, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h5A5A,
                            4'h0, 4'hF, 0);
            end
            idx = $urandom_range(0, 9);
            if (idx == 0) begin
                add_job(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 4'($urandom), 4'($urandom), i % 300 == 0);
            end else if (idx <= 3 && issued_q.size() > 0) begin
                idx = $urandom_range(0, issued_q.size() - 1);
                d = issued_q[idx];
                issued_q.delete(idx);
                add_job(OP_RELEASE, d.type_id_0, d.type_id_1, d.type_id_2, d.type_id_3,
                        d.write_mask, d.slot_valid_mask, i % 300 == 0);
            end else begin
                t = pick_type();
                add_job(OP_ACQUIRE, t, ($urandom_range(0, 7) == 0) ? t : pick_type(),
                        pick_type(), pick_type(), 4'($urandom), 4'($urandom),
                        i % 300 == 0);
            end
            if (issued_q.size() > 64)
                void'(issued_q.pop_front());
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !in_valid);
        wait (grant_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
